### rtl/core/plt_pkg.sv
// Package with the shared constants, codes and types of the port link table.
`timescale 1ns / 1ps

package plt_pkg;

  // Table geometry and field widths.
  localparam int TABLE_DEPTH   = 16;
  localparam int NODE_KEY_BITS = 16;
  localparam int PORT_BITS     = 4;
  localparam int IDX_BITS      = $clog2(TABLE_DEPTH);
  localparam int CNT_BITS      = $clog2(TABLE_DEPTH + 1);

  // Operation codes carried on the input stream.
  typedef enum logic [1:0] {
    OP_CONNECT  = 2'd0,
    OP_DETACH   = 2'd1,
    OP_READ     = 2'd2,
    OP_READ_ALT = 2'd3
  } opcode_t;

  // Status codes returned with every result.
  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_REPLACED  = 3'd1,
    ST_SELF      = 3'd2,
    ST_FULL      = 3'd3,
    ST_REMOVED   = 3'd4,
    ST_NOT_FOUND = 3'd5,
    ST_READ_DONE = 3'd6,
    ST_UNUSED    = 3'd7
  } status_t;

  // One stored link.
  typedef struct packed {
    logic [PORT_BITS-1:0]     dst_port;
    logic [NODE_KEY_BITS-1:0] dst_node;
    logic [PORT_BITS-1:0]     src_port;
    logic [NODE_KEY_BITS-1:0] src_node;
  } link_t;

  // Write request into the link store.
  typedef struct packed {
    logic                en;
    logic [IDX_BITS-1:0] addr;
    link_t               data;
  } mem_wr_t;

  // Read request into the link store.
  typedef struct packed {
    logic                en;
    logic [IDX_BITS-1:0] addr;
  } mem_rd_t;

  // Input transfer layout, last field in the lowest bits.
  typedef struct packed {
    logic [1:0]               pad;
    logic [3:0]               entry_index;
    logic [3:0]               dst_port;
    logic [15:0]              dst_node;
    logic [3:0]               src_port;
    logic [15:0]              src_node;
    logic [1:0]               opcode;
  } in_item_t;

  // Output transfer layout, last field in the lowest bits.
  typedef struct packed {
    logic [6:0]               pad;
    logic [3:0]               read_dst_port;
    logic [15:0]              read_dst_node;
    logic [3:0]               read_src_port;
    logic [15:0]              read_src_node;
    logic                     entry_valid;
    logic [4:0]               link_count;
    logic [2:0]               status;
  } out_item_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_MOVE,
    S_APPEND,
    S_READ_WAIT,
    S_DONE
  } state_t;

endpackage

### rtl/core/plt_store.sv
// Link store: one synchronous memory with one write and one registered read port.
`timescale 1ns / 1ps

module plt_store (
  input  logic           clk,
  input  plt_pkg::mem_wr_t wr,
  input  plt_pkg::mem_rd_t rd,
  output plt_pkg::link_t rd_data
);
  import plt_pkg::*;

  link_t mem [TABLE_DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

### rtl/core/port_link_table.sv
// Top level of the port link table: request decode, table scan and result stage.
//
//   channel   direction  handshake                      payload
//   s_axis    in         s_axis_tvalid / s_axis_tready  s_axis_tdata[47:0] request
//   m_axis    out        m_axis_tvalid / m_axis_tready  m_axis_tdata[55:0] result
//
// One request is worked at a time. A read passes through the start state, the
// read-wait state when its index is in range, and the done state; connect and detach
// scan the table, reading one table entry per cycle through the single read port.
// Reset (rst, synchronous) empties the table and clears the result stage.
// A result waiting on m_axis does not block the next request transfer.
`timescale 1ns / 1ps

module port_link_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode, src_node, src_port, dst_node, dst_port, entry_index, zero pad
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status, link_count, entry_valid, read_src_node, read_src_port,
  // read_dst_node, read_dst_port, zero pad
  output logic [55:0] m_axis_tdata
);
  import plt_pkg::*;

  state_t              state;
  state_t              state_next;
  in_item_t            in_item;
  in_item_t            req;
  logic [CNT_BITS-1:0] count;
  logic [CNT_BITS-1:0] count_last;
  logic [CNT_BITS-1:0] scan_idx;
  logic                chk_valid;
  logic                chk_valid_next;
  logic [IDX_BITS-1:0] chk_idx;
  logic [IDX_BITS-1:0] hole;
  logic                found;
  logic                match;
  logic                out_free;
  logic                is_read;
  status_t             res_status;
  logic                res_valid;
  link_t               res_entry;
  link_t               new_link;
  link_t               rd_data;
  mem_wr_t             wr;
  mem_rd_t             rd;
  out_item_t           out_item;

  assign in_item    = in_item_t'(s_axis_tdata);
  assign count_last = count - CNT_BITS'(1);
  assign out_free   = !m_axis_tvalid || m_axis_tready;
  assign is_read    = (req.opcode == OP_READ) || (req.opcode == OP_READ_ALT);
  assign s_axis_tready = (state == S_IDLE);
  assign match = chk_valid && (rd_data.dst_node == req.dst_node)
                 && (rd_data.dst_port == req.dst_port);

  assign new_link.src_node = req.src_node;
  assign new_link.src_port = req.src_port;
  assign new_link.dst_node = req.dst_node;
  assign new_link.dst_port = req.dst_port;

  plt_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  // Next state and memory control.
  always_comb begin
    state_next     = state;
    rd             = '0;
    wr             = '0;
    chk_valid_next = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = S_START;
        end
      end
      S_START: begin
        if (is_read) begin
          if (CNT_BITS'(req.entry_index) < count) begin
            rd.en      = 1'b1;
            rd.addr    = req.entry_index;
            state_next = S_READ_WAIT;
          end else begin
            state_next = S_DONE;
          end
        end else if (req.opcode == OP_CONNECT && req.src_node == req.dst_node) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (match) begin
          // Fetch the last entry to fill the hole.
          rd.en      = 1'b1;
          rd.addr    = count_last[IDX_BITS-1:0];
          state_next = S_MOVE;
        end else if (scan_idx < count) begin
          rd.en          = 1'b1;
          rd.addr        = scan_idx[IDX_BITS-1:0];
          chk_valid_next = 1'b1;
        end else if (req.opcode == OP_CONNECT) begin
          state_next = S_APPEND;
        end else begin
          state_next = S_DONE;
        end
      end
      S_MOVE: begin
        wr.en   = 1'b1;
        wr.addr = hole;
        wr.data = rd_data;
        state_next = (req.opcode == OP_CONNECT) ? S_APPEND : S_DONE;
      end
      S_APPEND: begin
        if (count != CNT_BITS'(TABLE_DEPTH)) begin
          wr.en   = 1'b1;
          wr.addr = count[IDX_BITS-1:0];
          wr.data = new_link;
        end
        state_next = S_DONE;
      end
      S_READ_WAIT: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Link count and scan control.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      chk_valid <= 1'b0;
    end else begin
      chk_valid <= chk_valid_next;
      if (state == S_MOVE) begin
        count <= count_last;
      end else if (wr.en && state == S_APPEND) begin
        count <= count + CNT_BITS'(1);
      end
    end
  end

  // Request capture, scan pointers and the staged result.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req <= in_item;
    end
    if (chk_valid_next) begin
      chk_idx  <= scan_idx[IDX_BITS-1:0];
      scan_idx <= scan_idx + CNT_BITS'(1);
    end
    case (state)
      S_START: begin
        scan_idx   <= '0;
        found      <= 1'b0;
        res_valid  <= 1'b0;
        res_entry  <= '0;
        res_status <= is_read ? ST_READ_DONE : ST_SELF;
      end
      S_SCAN: begin
        if (match) begin
          hole  <= chk_idx;
          found <= 1'b1;
        end
        if (!match && scan_idx >= count) begin
          res_status <= ST_NOT_FOUND;
        end
      end
      S_MOVE: begin
        res_status <= ST_REMOVED;
      end
      S_APPEND: begin
        if (count == CNT_BITS'(TABLE_DEPTH)) begin
          res_status <= ST_FULL;
        end else begin
          res_status <= found ? ST_REPLACED : ST_ADDED;
        end
      end
      S_READ_WAIT: begin
        res_valid <= 1'b1;
        res_entry <= rd_data;
      end
      default: begin
      end
    endcase
  end

  // Output register; loaded once per request.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_item.pad           <= '0;
      out_item.status        <= res_status;
      out_item.link_count    <= count;
      out_item.entry_valid   <= res_valid;
      out_item.read_src_node <= res_entry.src_node;
      out_item.read_src_port <= res_entry.src_port;
      out_item.read_dst_node <= res_entry.dst_node;
      out_item.read_dst_port <= res_entry.dst_port;
    end
  end

  assign m_axis_tdata = out_item;

  // The table never holds more links than it has entries.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(TABLE_DEPTH))
    else $error("link count exceeds table depth");

  // Writes land inside the filled part of the table or just past it.
  a_write_addr: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (CNT_BITS'(wr.addr) <= count))
    else $error("table write beyond fill level");

  // Leaving the result state always presents a result.
  a_result_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> m_axis_tvalid)
    else $error("result lost at output stage");

endmodule
